>>> design/spp_pkg.sv
// ----------------------------------------------------------------------------
// Signature path prefetch trainer package
// Shared constants and the queue record passed from front to back.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int TableEntries = 256;
  localparam int PatternRows  = 512;
  localparam int DeltaSlots   = 3;
  localparam int AddressBits  = 48;

  localparam int PageShift  = 12;
  localparam int BlockShift = 6;
  localparam int OffW       = 6;
  localparam int SigW       = 16;
  localparam int DeltaW     = 7;
  localparam int CntW       = 4;
  localparam int StampW     = 64;
  localparam logic [CntW-1:0] CountMax = 4'd15;

  // front-end result, queued for pattern table training
  typedef struct packed {
    logic            hit;
    logic [7:0]      entry;
    logic [DeltaW-1:0] delta;
    logic [SigW-1:0] old_sig;
    logic [SigW-1:0] new_sig;
  } front_rec_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SCAN,
    FS_WRITE
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_WAIT,
    BS_TRAIN
  } back_state_e;

endpackage

>>> design/spp_front.sv
// ----------------------------------------------------------------------------
// Signature table front end
// Scans the signature table one entry a cycle: page match, first invalid
// entry and least recently used entry; then updates the chosen entry.
// ----------------------------------------------------------------------------
module spp_front #(
  parameter int TableEntries = spp_pkg::TableEntries
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [47:0]              addr_i,
  output logic                     busy_o,
  output logic                     push_o,
  output spp_pkg::front_rec_t      rec_o,
  input  logic                     full_i
);

  localparam int AddressBits = spp_pkg::AddressBits;
  localparam int IdxW  = $clog2(TableEntries);
  localparam int TagW  = AddressBits - spp_pkg::PageShift;
  localparam int OffW  = spp_pkg::OffW;
  localparam int SigW  = spp_pkg::SigW;
  localparam int StW   = spp_pkg::StampW;

  logic [TagW-1:0] tag_mem [TableEntries];
  logic [SigW-1:0] sig_mem [TableEntries];
  logic [OffW-1:0] off_mem [TableEntries];
  logic [StW-1:0]  stamp_mem [TableEntries];
  logic [TableEntries-1:0] valid_q;

  spp_pkg::front_state_e state_q, state_d;
  logic [IdxW:0]   scan_q;
  logic [TagW-1:0] page_q;
  logic [OffW-1:0] off_q;
  logic            hit_q, inv_q;
  logic [IdxW-1:0] hit_idx_q, inv_idx_q, lru_idx_q;
  logic [StW-1:0]  lru_stamp_q;
  logic [SigW-1:0] hit_sig_q;
  logic [OffW-1:0] hit_off_q;
  logic [StW-1:0]  count_q;
  logic            rd_v_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [TagW-1:0] rd_tag_q;
  logic [SigW-1:0] rd_sig_q;
  logic [OffW-1:0] rd_off_q;
  logic [StW-1:0]  rd_stamp_q;
  logic            rd_valid_q;

  logic [47:0] addr_m;
  logic [IdxW-1:0] sel_idx;
  logic [SigW-1:0] delta16;
  logic [SigW-1:0] nsig;
  logic [IdxW-1:0] scan_idx;

  assign addr_m   = addr_i;
  assign scan_idx = scan_q[IdxW-1:0];
  assign busy_o   = (state_q != spp_pkg::FS_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spp_pkg::FS_IDLE:  if (start_i) state_d = spp_pkg::FS_SCAN;
      spp_pkg::FS_SCAN:  if (scan_q == (IdxW+1)'(TableEntries) && !rd_v_q)
                           state_d = spp_pkg::FS_WRITE;
      spp_pkg::FS_WRITE: if (!full_i) state_d = spp_pkg::FS_IDLE;
      default:           state_d = spp_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= spp_pkg::FS_IDLE;
    else         state_q <= state_d;
  end

  // registered read of one entry a cycle
  always_ff @(posedge clk_i) begin
    rd_tag_q   <= tag_mem[scan_idx];
    rd_sig_q   <= sig_mem[scan_idx];
    rd_off_q   <= off_mem[scan_idx];
    rd_stamp_q <= stamp_mem[scan_idx];
    rd_valid_q <= valid_q[scan_idx];
    rd_idx_q   <= scan_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      rd_v_q  <= 1'b0;
      hit_q   <= 1'b0;
      inv_q   <= 1'b0;
      count_q <= '0;
      valid_q <= '0;
    end else begin
      rd_v_q <= (state_q == spp_pkg::FS_SCAN) && (scan_q < (IdxW+1)'(TableEntries));
      if (state_q == spp_pkg::FS_IDLE && start_i) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
        inv_q  <= 1'b0;
      end else if (state_q == spp_pkg::FS_SCAN &&
                   scan_q < (IdxW+1)'(TableEntries)) begin
        scan_q <= scan_q + 1'b1;
      end
      if (rd_v_q) begin
        if (rd_valid_q && rd_tag_q == page_q && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!rd_valid_q && !inv_q) begin
          inv_q <= 1'b1;
        end
      end
      if (state_q == spp_pkg::FS_WRITE && !full_i) begin
        valid_q[sel_idx] <= 1'b1;
        count_q <= count_q + 1'b1;
      end
    end
  end

  // payload of the scan, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == spp_pkg::FS_IDLE && start_i) begin
      page_q <= addr_m[AddressBits-1:spp_pkg::PageShift];
      off_q  <= addr_m[spp_pkg::PageShift-1:spp_pkg::BlockShift];
    end
    if (rd_v_q) begin
      if (rd_valid_q && rd_tag_q == page_q && !hit_q) begin
        hit_idx_q <= rd_idx_q;
        hit_sig_q <= rd_sig_q;
        hit_off_q <= rd_off_q;
      end
      if (!rd_valid_q && !inv_q) inv_idx_q <= rd_idx_q;
      if (rd_idx_q == '0 || rd_stamp_q < lru_stamp_q) begin
        lru_idx_q   <= rd_idx_q;
        lru_stamp_q <= rd_stamp_q;
      end
    end
  end

  always_comb begin
    priority if (hit_q) sel_idx = hit_idx_q;
    else if (inv_q)     sel_idx = inv_idx_q;
    else                sel_idx = lru_idx_q;
    delta16 = hit_q ? (SigW'(off_q) - SigW'(hit_off_q)) : '0;
    nsig    = hit_q ? ((hit_sig_q << 3) ^ delta16) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == spp_pkg::FS_WRITE && !full_i) begin
      tag_mem[sel_idx]   <= page_q;
      sig_mem[sel_idx]   <= nsig;
      off_mem[sel_idx]   <= off_q;
      stamp_mem[sel_idx] <= count_q;
    end
  end

  // invalid entries win first, ahead of the least recently used entry
  assign push_o        = (state_q == spp_pkg::FS_WRITE) && !full_i;
  assign rec_o.hit     = hit_q;
  assign rec_o.entry   = 8'(sel_idx);
  assign rec_o.delta   = delta16[spp_pkg::DeltaW-1:0];
  assign rec_o.old_sig = hit_q ? hit_sig_q : '0;
  assign rec_o.new_sig = nsig;

endmodule

>>> design/spp_queue.sv
// ----------------------------------------------------------------------------
// Front-to-back queue
// Two-entry FIFO of front-end records.
// ----------------------------------------------------------------------------
module spp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  spp_pkg::front_rec_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output spp_pkg::front_rec_t data_o
);

  spp_pkg::front_rec_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

>>> design/spp_back.sv
// ----------------------------------------------------------------------------
// Pattern table back end
// Clears the pattern table after reset, then reads one pattern row, trains
// signature and delta counters, writes back and issues the result beat.
// ----------------------------------------------------------------------------
module spp_back #(
  parameter int PatternRows = spp_pkg::PatternRows,
  parameter int DeltaSlots  = spp_pkg::DeltaSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  spp_pkg::front_rec_t rec_i,
  output logic                pop_o,
  output logic                done_o,
  output logic                table_hit_o,
  output logic [7:0]          entry_index_o,
  output logic signed [6:0]   access_delta_o,
  output logic [15:0]         trained_signature_o,
  output logic [15:0]         new_signature_o,
  output logic [8:0]          pattern_row_o,
  output logic [3:0]          signature_count_o,
  output logic [1:0]          predictor_slot_o,
  output logic [3:0]          slot_count_o,
  output logic                slot_replaced_o
);

  localparam int RowW  = $clog2(PatternRows);
  localparam int SlotW = (DeltaSlots > 1) ? $clog2(DeltaSlots) : 1;
  localparam int DW    = spp_pkg::DeltaW;
  localparam int CW    = spp_pkg::CntW;
  localparam int RowBits = CW + DeltaSlots * (DW + CW);

  // row = {sig count, slots of {delta, count}}
  logic [RowBits-1:0] row_mem [PatternRows];

  spp_pkg::back_state_e state_q, state_d;
  spp_pkg::front_rec_t  rec_q;
  logic [RowBits-1:0]   rd_q;
  logic                 clr_q;
  logic [RowW-1:0]      clr_idx_q;
  logic [RowW-1:0]      row;
  logic [RowBits-1:0]   cur, wr;
  logic [CW-1:0]        sc;
  logic                 matched;
  logic [SlotW-1:0]     mslot, lslot, slot;
  logic [CW-1:0]        scnt;
  logic [DW-1:0]        sd [DeltaSlots];
  logic [CW-1:0]        sn [DeltaSlots];

  assign row = rec_q.old_sig[RowW-1:0];
  assign cur = rd_q;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      // hold the queue until the clearing pass is over
      spp_pkg::BS_IDLE: if (!empty_i && !clr_q) begin
        pop_o   = 1'b1;
        state_d = spp_pkg::BS_READ;
      end
      spp_pkg::BS_READ:  state_d = spp_pkg::BS_WAIT;
      spp_pkg::BS_WAIT:  state_d = spp_pkg::BS_TRAIN;
      spp_pkg::BS_TRAIN: state_d = spp_pkg::BS_IDLE;
      default:           state_d = spp_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spp_pkg::BS_IDLE;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      done_o    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == spp_pkg::BS_TRAIN);
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == RowW'(PatternRows - 1)) clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= rec_i;
    if (state_q == spp_pkg::BS_READ) rd_q <= row_mem[row];
    if (clr_q) row_mem[clr_idx_q] <= '0;
    else if (state_q == spp_pkg::BS_TRAIN) row_mem[row] <= wr;
  end

  always_comb begin
    for (int i = 0; i < DeltaSlots; i++) begin
      sd[i] = cur[i*(DW+CW)+CW +: DW];
      sn[i] = cur[i*(DW+CW) +: CW];
    end
    sc = cur[RowBits-1 -: CW];
    sc = (sc == spp_pkg::CountMax) ? sc : sc + 1'b1;
    matched = 1'b0;
    mslot = '0;
    lslot = '0;
    for (int i = 0; i < DeltaSlots; i++) begin
      if (!matched && sd[i] == rec_q.delta) begin
        matched = 1'b1;
        mslot = SlotW'(i);
      end
      if (sn[i] < sn[lslot]) lslot = SlotW'(i);
    end
    slot = matched ? mslot : lslot;
    scnt = matched ? ((sn[mslot] == spp_pkg::CountMax) ? sn[mslot] : sn[mslot] + 1'b1)
                   : CW'(1);
    wr = cur;
    wr[RowBits-1 -: CW] = sc;
    for (int i = 0; i < DeltaSlots; i++) begin
      if (SlotW'(i) == slot) begin
        wr[i*(DW+CW)+CW +: DW] = rec_q.delta;
        wr[i*(DW+CW) +: CW]    = scnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == spp_pkg::BS_TRAIN) begin
      table_hit_o         <= rec_q.hit;
      entry_index_o       <= rec_q.entry;
      access_delta_o      <= rec_q.delta;
      trained_signature_o <= rec_q.old_sig;
      new_signature_o     <= rec_q.new_sig;
      pattern_row_o       <= 9'(row);
      signature_count_o   <= sc;
      predictor_slot_o    <= 2'(slot);
      slot_count_o        <= scnt;
      slot_replaced_o     <= !matched;
    end
  end

endmodule

>>> design/signature_path_prefetch_trainer_top.sv
// ----------------------------------------------------------------------------
// Signature path prefetch trainer
// Signature table lookup and pattern table training.
// ----------------------------------------------------------------------------
// Front end: each access is paced by the one-entry-a-cycle scan of the
// signature table; busy stays high through the scan and the write.
// Back end: pop, READ, WAIT, TRAIN, done_o; queue lets the next scan start.
// Reset clears the valid bits; the back end then clears the pattern table in
// a pass over every row and holds training until it ends.
// The receiver cannot stall: each result is shown for one cycle on done_o.
module signature_path_prefetch_trainer_top #(
  parameter int TableEntries = spp_pkg::TableEntries,
  parameter int PatternRows  = spp_pkg::PatternRows,
  parameter int DeltaSlots   = spp_pkg::DeltaSlots
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [47:0]       access_address_i,
  output logic              done_o,
  output logic              table_hit_o,
  output logic [7:0]        entry_index_o,
  output logic signed [6:0] access_delta_o,
  output logic [15:0]       trained_signature_o,
  output logic [15:0]       new_signature_o,
  output logic [8:0]        pattern_row_o,
  output logic [3:0]        signature_count_o,
  output logic [1:0]        predictor_slot_o,
  output logic [3:0]        slot_count_o,
  output logic              slot_replaced_o
);

  logic push, full, pop, empty;
  spp_pkg::front_rec_t frec, qrec;

  spp_front #(.TableEntries(TableEntries)) u_front (
    .clk_i, .rst_ni, .start_i(start), .addr_i(access_address_i),
    .busy_o(busy), .push_o(push), .rec_o(frec), .full_i(full)
  );

  spp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(frec), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qrec)
  );

  spp_back #(.PatternRows(PatternRows), .DeltaSlots(DeltaSlots)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .rec_i(qrec), .pop_o(pop),
    .done_o, .table_hit_o, .entry_index_o, .access_delta_o, .trained_signature_o,
    .new_signature_o, .pattern_row_o, .signature_count_o, .predictor_slot_o,
    .slot_count_o, .slot_replaced_o
  );

endmodule

>>> design/spp_checker.sv
// ----------------------------------------------------------------------------
// Trainer port checker
// Checks result beats against the access handshake.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       table_hit_o,
  input logic signed [6:0] access_delta_o,
  input logic [15:0] trained_signature_o,
  input logic [15:0] new_signature_o,
  input logic [8:0] pattern_row_o,
  input logic [3:0] slot_count_o,
  input logic       slot_replaced_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !table_hit_o |-> access_delta_o == 7'sd0 &&
    trained_signature_o == 16'd0 && new_signature_o == 16'd0)
    else $error("miss beat carries signature");

  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pattern_row_o == trained_signature_o[8:0])
    else $error("row mismatch");

  a_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && slot_replaced_o |-> slot_count_o == 4'd1)
    else $error("replaced slot count not one");

endmodule

bind signature_path_prefetch_trainer_top spp_checker u_spp_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .table_hit_o, .access_delta_o,
  .trained_signature_o, .new_signature_o, .pattern_row_o, .slot_count_o,
  .slot_replaced_o
);
